@@ rtl/core/sts_pkg.sv @@
// Shared types and constants for the script token scanner.
package sts_pkg;

    localparam int POS_BITS_DEFAULT      = 16;
    localparam int KEYWORD_BYTES_DEFAULT = 8;
    localparam int KEYWORD_COUNT         = 10;
    localparam int QUEUE_DEPTH           = 4;

    // Result kinds.
    localparam logic [1:0] RK_TOKEN = 2'd0;
    localparam logic [1:0] RK_ERROR = 2'd1;
    localparam logic [1:0] RK_END   = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED = 2'd2;

    // Token types.
    localparam logic [5:0] TT_STRING   = 6'd0;
    localparam logic [5:0] TT_EQEQ     = 6'd1;
    localparam logic [5:0] TT_ASSIGN   = 6'd2;
    localparam logic [5:0] TT_SEMI     = 6'd3;
    localparam logic [5:0] TT_LBRACE   = 6'd4;
    localparam logic [5:0] TT_LPAREN   = 6'd5;
    localparam logic [5:0] TT_RPAREN   = 6'd6;
    localparam logic [5:0] TT_LBRACKET = 6'd7;
    localparam logic [5:0] TT_RBRACKET = 6'd8;
    localparam logic [5:0] TT_RBRACE   = 6'd9;
    localparam logic [5:0] TT_DOT      = 6'd10;
    localparam logic [5:0] TT_COMMA    = 6'd11;
    localparam logic [5:0] TT_PLUS     = 6'd12;
    localparam logic [5:0] TT_MINUS    = 6'd13;
    localparam logic [5:0] TT_STAR     = 6'd14;
    localparam logic [5:0] TT_SLASH    = 6'd15;
    localparam logic [5:0] TT_NE       = 6'd16;
    localparam logic [5:0] TT_NOT      = 6'd17;
    localparam logic [5:0] TT_ANDAND   = 6'd18;
    localparam logic [5:0] TT_OROR     = 6'd19;
    localparam logic [5:0] TT_LE       = 6'd20;
    localparam logic [5:0] TT_LT       = 6'd21;
    localparam logic [5:0] TT_GE       = 6'd22;
    localparam logic [5:0] TT_GT       = 6'd23;
    localparam logic [5:0] TT_DOLLAR   = 6'd24;
    localparam logic [5:0] TT_NUMBER   = 6'd25;
    localparam logic [5:0] TT_KEY0     = 6'd26;
    localparam logic [5:0] TT_NAME     = 6'd36;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // Keywords written back to front so that byte 0 holds the first character.
    localparam logic [KEYWORD_COUNT-1:0][63:0] KW_TEXT = '{
        64'("kaerb"), 64'("elihw"), 64'("esle"), 64'("file"), 64'("fi"),
        64'("ssalc"), 64'("nruter"), 64'("noitcnuf"), 64'("yarra"), 64'("rav")
    };
    localparam logic [KEYWORD_COUNT-1:0][3:0] KW_LEN = '{
        4'd5, 4'd5, 4'd4, 4'd4, 4'd2, 4'd5, 4'd6, 4'd8, 4'd5, 4'd3
    };

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [5:0]  token_type;
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_of_run;
    } res_t;

endpackage

@@ rtl/core/script_token_scanner.sv @@
// Script token scanner: byte-at-a-time lexer with a small result queue.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  src      | src_valid/src_stall  | kind, text_byte
//  res      | res_valid/res_stall  | result_kind, token_type, token_offset,
//           |                      | token_length, line_number, error_code, last_of_run
//
// Each accepted byte is scanned in the cycle it arrives.
// A byte yields up to three results, written at once into a four-entry result queue.
// The source side stalls while the queue holds two or more results, so one byte per
// cycle is sustained as long as results drain about as fast as they are made.
// Reset (rst_n low) clears the scanner state and empties the queue.
// A stall on the result side backs up into the queue and then onto the source side.
module script_token_scanner #(
    parameter int POS_BITS      = sts_pkg::POS_BITS_DEFAULT,
    parameter int KEYWORD_BYTES = sts_pkg::KEYWORD_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic        kind,
    input  logic [7:0]  text_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  result_kind,
    output logic [5:0]  token_type,
    output logic [15:0] token_offset,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    localparam int IDX_BITS = (KEYWORD_BYTES > 1) ? $clog2(KEYWORD_BYTES) : 1;
    localparam int QP_BITS  = $clog2(sts_pkg::QUEUE_DEPTH);
    localparam int QC_BITS  = QP_BITS + 1;

    typedef enum logic [14:0] {
        M_IDLE    = 15'b000000000000001,
        M_STRING  = 15'b000000000000010,
        M_COMMENT = 15'b000000000000100,
        M_SLASH   = 15'b000000000001000,
        M_EQ      = 15'b000000000010000,
        M_BANG    = 15'b000000000100000,
        M_LT      = 15'b000000001000000,
        M_GT      = 15'b000000010000000,
        M_AMP     = 15'b000000100000000,
        M_BAR     = 15'b000001000000000,
        M_INT     = 15'b000010000000000,
        M_INTDOT  = 15'b000100000000000,
        M_FRAC    = 15'b001000000000000,
        M_NAME    = 15'b010000000000000,
        M_HALT    = 15'b100000000000000
    } mode_t;

    typedef logic [KEYWORD_BYTES-1:0][7:0] prefix_t;

    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [15:0]         line_reg, line_next;
    logic [POS_BITS-1:0] tb_reg, tb_next;
    prefix_t             prefix_reg, prefix_next;

    sts_pkg::res_t       queue_reg [sts_pkg::QUEUE_DEPTH];
    logic [QP_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QC_BITS-1:0]  count_reg, count_next;

    sts_pkg::res_t       res [3];
    logic [1:0]          res_cnt;
    logic                accept, pop;
    logic [7:0]          c;
    logic [POS_BITS-1:0] len, len_m1, pos_m1;
    logic                redo, is_dig, is_alp;
    logic [5:0]          name_tt;

    function automatic sts_pkg::res_t mk(input logic [1:0] rk, input logic [5:0] tt,
                                         input logic [15:0] off, input logic [15:0] ln,
                                         input logic [1:0] ec, input logic [15:0] line);
        sts_pkg::res_t r;
        r.result_kind  = rk;
        r.token_type   = tt;
        r.token_offset = off;
        r.token_length = ln;
        r.line_number  = line;
        r.error_code   = ec;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    assign src_stall = count_reg > QC_BITS'(1);
    assign accept    = src_valid && !src_stall;
    assign res_valid = count_reg != '0;
    assign pop       = res_valid && !res_stall;

    assign c      = kind ? 8'h00 : text_byte;
    assign len    = (pos_reg > tb_reg) ? pos_reg - tb_reg : '0;
    assign len_m1 = (len != '0) ? len - POS_BITS'(1) : '0;
    assign pos_m1 = (pos_reg != '0) ? pos_reg - POS_BITS'(1) : '0;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");

    // Keyword lookup: bytes past the name length are zero, as are the
    // keyword table's, so a full compare plus a length check suffices.
    always_comb
    begin
        name_tt = sts_pkg::TT_NAME;
        if (len <= POS_BITS'(KEYWORD_BYTES))
        begin
            for (int k = 0; k < sts_pkg::KEYWORD_COUNT; k++)
            begin
                if (len == POS_BITS'(sts_pkg::KW_LEN[k]) &&
                    prefix_reg == prefix_t'(sts_pkg::KW_TEXT[k]))
                begin
                    name_tt = sts_pkg::TT_KEY0 + 6'(k);
                end
            end
        end
    end

    // One scanning step: the pending mode first, then, if the byte was not
    // consumed, the idle handling of the same byte.
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        tb_next     = tb_reg;
        prefix_next = prefix_reg;
        redo        = 1'b0;
        res_cnt     = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end

        unique case (mode_reg)
            M_STRING:
            begin
                if (c == 8'h00)
                begin
                    res[res_cnt] = mk(sts_pkg::RK_ERROR, 6'd0, 16'(tb_reg), 16'd0,
                                      sts_pkg::ERR_UNCLOSED, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_HALT;
                end
                else if (c == sts_pkg::CH_QUOTE)
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN, sts_pkg::TT_STRING,
                                      16'(tb_reg) + 16'd1, 16'(len_m1),
                                      sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_IDLE;
                end
                else if (c == "\n" && line_reg != 16'hFFFF)
                begin
                    line_next = line_reg + 16'd1;
                end
            end
            M_COMMENT:
            begin
                if (c == 8'h00 || c == "\n")
                begin
                    mode_next = M_IDLE;
                    redo = 1'b1;
                end
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    mode_next = M_COMMENT;
                end
                else
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN, sts_pkg::TT_SLASH, 16'(tb_reg),
                                      16'd1, sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_IDLE;
                    redo = 1'b1;
                end
            end
            M_EQ, M_BANG, M_LT, M_GT:
            begin
                mode_next = M_IDLE;
                if (c == "=")
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN,
                                      (mode_reg == M_EQ)   ? sts_pkg::TT_EQEQ :
                                      (mode_reg == M_BANG) ? sts_pkg::TT_NE :
                                      (mode_reg == M_LT)   ? sts_pkg::TT_LE : sts_pkg::TT_GE,
                                      16'(tb_reg), 16'd2, sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                end
                else
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN,
                                      (mode_reg == M_EQ)   ? sts_pkg::TT_ASSIGN :
                                      (mode_reg == M_BANG) ? sts_pkg::TT_NOT :
                                      (mode_reg == M_LT)   ? sts_pkg::TT_LT : sts_pkg::TT_GT,
                                      16'(tb_reg), 16'd1, sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    redo = 1'b1;
                end
            end
            M_AMP, M_BAR:
            begin
                if ((mode_reg == M_AMP && c == "&") || (mode_reg == M_BAR && c == "|"))
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN,
                                      (mode_reg == M_AMP) ? sts_pkg::TT_ANDAND
                                                          : sts_pkg::TT_OROR,
                                      16'(tb_reg), 16'd2, sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    res[res_cnt] = mk(sts_pkg::RK_ERROR, 6'd0, 16'(tb_reg), 16'd0,
                                      sts_pkg::ERR_BAD_CHAR, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_HALT;
                end
            end
            M_INT, M_FRAC:
            begin
                if (mode_reg == M_INT && c == ".")
                begin
                    mode_next = M_INTDOT;
                end
                else if (!is_dig)
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN, sts_pkg::TT_NUMBER, 16'(tb_reg),
                                      16'(len), sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_IDLE;
                    redo = 1'b1;
                end
            end
            M_INTDOT:
            begin
                if (is_dig)
                begin
                    mode_next = M_FRAC;
                end
                else
                begin
                    // The dot was not a decimal point: number, then attribute dot.
                    res[0] = mk(sts_pkg::RK_TOKEN, sts_pkg::TT_NUMBER, 16'(tb_reg),
                                16'(len_m1), sts_pkg::ERR_NONE, line_reg);
                    res[1] = mk(sts_pkg::RK_TOKEN, sts_pkg::TT_DOT, 16'(pos_m1), 16'd1,
                                sts_pkg::ERR_NONE, line_reg);
                    res_cnt = 2'd2;
                    mode_next = M_IDLE;
                    redo = 1'b1;
                end
            end
            M_NAME:
            begin
                if (is_alp || is_dig)
                begin
                    if (len < POS_BITS'(KEYWORD_BYTES))
                    begin
                        prefix_next[len[IDX_BITS-1:0]] = c;
                    end
                end
                else
                begin
                    res[res_cnt] = mk(sts_pkg::RK_TOKEN, name_tt, 16'(tb_reg), 16'(len),
                                      sts_pkg::ERR_NONE, line_reg);
                    res_cnt = res_cnt + 2'd1;
                    mode_next = M_IDLE;
                    redo = 1'b1;
                end
            end
            M_HALT:
            begin
                mode_next = M_HALT;
            end
            default:
            begin
                mode_next = M_IDLE;
                redo = 1'b1;
            end
        endcase

        if (redo)
        begin
            priority if (c == 8'h00)
            begin
                res[res_cnt] = mk(sts_pkg::RK_END, 6'd0, 16'(pos_reg), 16'd0,
                                  sts_pkg::ERR_NONE, line_reg);
                res_cnt = res_cnt + 2'd1;
                mode_next   = M_IDLE;
                pos_next    = '0;
                line_next   = 16'd0;
                tb_next     = '0;
                prefix_next = '0;
            end
            else if (c == " " || c == "\t")
            begin
                mode_next = M_IDLE;
            end
            else if (c == "\n")
            begin
                if (line_reg != 16'hFFFF)
                begin
                    line_next = line_reg + 16'd1;
                end
            end
            else if (c == sts_pkg::CH_QUOTE || c == "/" || c == "=" || c == "!" ||
                     c == "<" || c == ">" || c == "&" || c == "|" || is_dig)
            begin
                tb_next = pos_reg;
                priority if (c == sts_pkg::CH_QUOTE) mode_next = M_STRING;
                else if (c == "/") mode_next = M_SLASH;
                else if (c == "=") mode_next = M_EQ;
                else if (c == "!") mode_next = M_BANG;
                else if (c == "<") mode_next = M_LT;
                else if (c == ">") mode_next = M_GT;
                else if (c == "&") mode_next = M_AMP;
                else if (c == "|") mode_next = M_BAR;
                else mode_next = M_INT;
            end
            else if (is_alp)
            begin
                tb_next     = pos_reg;
                mode_next   = M_NAME;
                prefix_next = '0;
                prefix_next[0] = c;
            end
            else if (c == ";" || c == "{" || c == "(" || c == ")" || c == "[" ||
                     c == "]" || c == "}" || c == "." || c == "," || c == "+" ||
                     c == "-" || c == "*" || c == sts_pkg::CH_DOLLAR)
            begin
                res[res_cnt] = mk(sts_pkg::RK_TOKEN,
                                  (c == ";") ? sts_pkg::TT_SEMI :
                                  (c == "{") ? sts_pkg::TT_LBRACE :
                                  (c == "(") ? sts_pkg::TT_LPAREN :
                                  (c == ")") ? sts_pkg::TT_RPAREN :
                                  (c == "[") ? sts_pkg::TT_LBRACKET :
                                  (c == "]") ? sts_pkg::TT_RBRACKET :
                                  (c == "}") ? sts_pkg::TT_RBRACE :
                                  (c == ".") ? sts_pkg::TT_DOT :
                                  (c == ",") ? sts_pkg::TT_COMMA :
                                  (c == "+") ? sts_pkg::TT_PLUS :
                                  (c == "-") ? sts_pkg::TT_MINUS :
                                  (c == "*") ? sts_pkg::TT_STAR : sts_pkg::TT_DOLLAR,
                                  16'(pos_reg), 16'd1, sts_pkg::ERR_NONE, line_reg);
                res_cnt = res_cnt + 2'd1;
            end
            else
            begin
                res[res_cnt] = mk(sts_pkg::RK_ERROR, 6'd0, 16'(pos_reg), 16'd0,
                                  sts_pkg::ERR_BAD_CHAR, line_reg);
                res_cnt = res_cnt + 2'd1;
                mode_next = M_HALT;
            end
        end

        if (c != 8'h00 && mode_next != M_HALT && mode_reg != M_HALT && pos_reg != '1)
        begin
            pos_next = pos_reg + POS_BITS'(1);
        end

        for (int i = 0; i < 3; i++)
        begin
            res[i].last_of_run = (2'(i) + 2'd1 == res_cnt);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + QC_BITS'(res_cnt);
        end
        if (pop)
        begin
            count_next = count_next - QC_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= 16'd0;
            tb_reg     <= '0;
            prefix_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                line_reg   <= line_next;
                tb_reg     <= tb_next;
                prefix_reg <= prefix_next;
                wr_ptr_reg <= wr_ptr_reg + QP_BITS'(res_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QP_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < res_cnt)
                begin
                    queue_reg[wr_ptr_reg + QP_BITS'(i)] <= res[i];
                end
            end
        end
    end

    assign result_kind  = queue_reg[rd_ptr_reg].result_kind;
    assign token_type   = queue_reg[rd_ptr_reg].token_type;
    assign token_offset = queue_reg[rd_ptr_reg].token_offset;
    assign token_length = queue_reg[rd_ptr_reg].token_length;
    assign line_number  = queue_reg[rd_ptr_reg].line_number;
    assign error_code   = queue_reg[rd_ptr_reg].error_code;
    assign last_of_run  = queue_reg[rd_ptr_reg].last_of_run;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC_BITS'(sts_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == M_HALT) |=> count_reg <= $past(count_reg))
        else $error("results produced after halt");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind && mode_reg != M_HALT) |=>
        ((mode_reg == M_IDLE && pos_reg == '0) || mode_reg == M_HALT))
        else $error("end of text did not restart the scanner");

    a_pos_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !kind && text_byte != 8'h00) |=>
        (pos_reg >= $past(pos_reg)))
        else $error("byte position moved backward");
`endif

endmodule

@@ verif/scanner_checker.sv @@
`timescale 1ns / 1ps
// Checker for the script token scanner: predicts results from accepted bytes and compares.
module scanner_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    input  logic        src_stall,
    input  logic        kind,
    input  logic [7:0]  text_byte,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [1:0]  result_kind,
    input  logic [5:0]  token_type,
    input  logic [15:0] token_offset,
    input  logic [15:0] token_length,
    input  logic [15:0] line_number,
    input  logic [1:0]  error_code,
    input  logic        last_of_run,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [3:0] {
        SM_IDLE, SM_STRING, SM_COMMENT, SM_SLASH, SM_EQ, SM_BANG, SM_LT, SM_GT,
        SM_AMP, SM_BAR, SM_INT, SM_INTDOT, SM_FRAC, SM_NAME, SM_HALT
    } scan_mode_t;

    localparam logic [15:0] POS_TOP = 16'hFFFF;
    localparam logic [15:0] LINE_TOP = 16'hFFFF;

    string keyword_words[sts_pkg::KEYWORD_COUNT] = '{"var", "array", "function", "return",
                                                     "class", "if", "elif", "else", "while",
                                                     "break"};

    scan_mode_t     mode;
    logic [15:0]    pos;
    logic [15:0]    line;
    logic [15:0]    tok_start;
    logic [7:0]     prefix [8];
    sts_pkg::res_t  step_q [$];
    sts_pkg::res_t  token_q [$];

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [15:0] sat_sub(logic [15:0] a, logic [15:0] b);
        return a > b ? a - b : 16'd0;
    endfunction

    // A name is a keyword only when its whole text fits in the prefix buffer.
    function automatic logic [5:0] classify_name(logic [15:0] len);
        bit same;
        if (len > 8)
            return sts_pkg::TT_NAME;
        for (int k = 0; k < sts_pkg::KEYWORD_COUNT; k++)
        begin
            if (keyword_words[k].len() == len)
            begin
                same = 1'b1;
                for (int i = 0; i < len; i++)
                    if (prefix[i] != keyword_words[k][i])
                        same = 1'b0;
                if (same)
                    return sts_pkg::TT_KEY0 + 6'(k);
            end
        end
        return sts_pkg::TT_NAME;
    endfunction

    task automatic emit(logic [1:0] rk, logic [5:0] tt, logic [15:0] off, logic [15:0] len,
                        logic [1:0] err);
        sts_pkg::res_t r;
        r.result_kind  = rk;
        r.token_type   = tt;
        r.token_offset = off;
        r.token_length = len;
        r.line_number  = line;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic raise_error(logic [15:0] off, logic [1:0] code);
        emit(sts_pkg::RK_ERROR, sts_pkg::TT_STRING, off, 16'd0, code);
        mode = SM_HALT;
    endtask

    task automatic bump_line();
        if (line != LINE_TOP)
            line++;
    endtask

    task automatic restart();
        mode      = SM_IDLE;
        pos       = '0;
        line      = '0;
        tok_start = '0;
        foreach (prefix[i])
            prefix[i] = 8'd0;
    endtask

    // Starts a token from the idle mode; a zero byte stands for end of text.
    task automatic start_token(logic [7:0] c, logic [15:0] p);
        bit          single;
        logic [5:0]  tt;
        single = 1'b1;
        tt     = sts_pkg::TT_STRING;
        case (c)
            8'h00:
            begin
                emit(sts_pkg::RK_END, sts_pkg::TT_STRING, p, 16'd0, sts_pkg::ERR_NONE);
                restart();
                return;
            end
            " ", "\t": return;
            "\n":
            begin
                bump_line();
                return;
            end
            sts_pkg::CH_QUOTE: begin mode = SM_STRING; single = 1'b0; end
            "/": begin mode = SM_SLASH; single = 1'b0; end
            "=": begin mode = SM_EQ; single = 1'b0; end
            "!": begin mode = SM_BANG; single = 1'b0; end
            "<": begin mode = SM_LT; single = 1'b0; end
            ">": begin mode = SM_GT; single = 1'b0; end
            "&": begin mode = SM_AMP; single = 1'b0; end
            "|": begin mode = SM_BAR; single = 1'b0; end
            ";": tt = sts_pkg::TT_SEMI;
            "{": tt = sts_pkg::TT_LBRACE;
            "(": tt = sts_pkg::TT_LPAREN;
            ")": tt = sts_pkg::TT_RPAREN;
            "[": tt = sts_pkg::TT_LBRACKET;
            "]": tt = sts_pkg::TT_RBRACKET;
            "}": tt = sts_pkg::TT_RBRACE;
            ".": tt = sts_pkg::TT_DOT;
            ",": tt = sts_pkg::TT_COMMA;
            "+": tt = sts_pkg::TT_PLUS;
            "-": tt = sts_pkg::TT_MINUS;
            "*": tt = sts_pkg::TT_STAR;
            sts_pkg::CH_DOLLAR: tt = sts_pkg::TT_DOLLAR;
            default:
            begin
                single = 1'b0;
                if (is_digit(c))
                    mode = SM_INT;
                else if (is_alpha(c))
                begin
                    mode = SM_NAME;
                    foreach (prefix[i])
                        prefix[i] = 8'd0;
                    prefix[0] = c;
                end
                else
                begin
                    raise_error(p, sts_pkg::ERR_BAD_CHAR);
                    return;
                end
            end
        endcase
        if (single)
            emit(sts_pkg::RK_TOKEN, tt, p, 16'd1, sts_pkg::ERR_NONE);
        else
            tok_start = p;
    endtask

    task automatic pair_op(logic [7:0] c, logic [5:0] t2, logic [5:0] t1, output bit redo);
        mode = SM_IDLE;
        redo = (c != "=");
        if (redo)
            emit(sts_pkg::RK_TOKEN, t1, tok_start, 16'd1, sts_pkg::ERR_NONE);
        else
            emit(sts_pkg::RK_TOKEN, t2, tok_start, 16'd2, sts_pkg::ERR_NONE);
    endtask

    task automatic scan_byte(logic k, logic [7:0] b);
        logic [7:0]  c;
        logic [15:0] p;
        logic [15:0] len;
        bit          redo;
        step_q.delete();
        if (mode == SM_HALT)
            return;
        c    = k ? 8'h00 : b;
        p    = pos;
        redo = 1'b0;
        len  = sat_sub(p, tok_start);
        case (mode)
            SM_STRING:
                if (c == 8'h00)
                    raise_error(tok_start, sts_pkg::ERR_UNCLOSED);
                else if (c == sts_pkg::CH_QUOTE)
                begin
                    emit(sts_pkg::RK_TOKEN, sts_pkg::TT_STRING, tok_start + 16'd1,
                         sat_sub(len, 16'd1), sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                end
                else if (c == "\n")
                    bump_line();
            SM_COMMENT:
                if (c == 8'h00 || c == "\n")
                begin
                    mode = SM_IDLE;
                    redo = 1'b1;
                end
            SM_SLASH:
                if (c == "/")
                    mode = SM_COMMENT;
                else
                begin
                    emit(sts_pkg::RK_TOKEN, sts_pkg::TT_SLASH, tok_start, 16'd1,
                         sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                    redo = 1'b1;
                end
            SM_EQ:   pair_op(c, sts_pkg::TT_EQEQ, sts_pkg::TT_ASSIGN, redo);
            SM_BANG: pair_op(c, sts_pkg::TT_NE, sts_pkg::TT_NOT, redo);
            SM_LT:   pair_op(c, sts_pkg::TT_LE, sts_pkg::TT_LT, redo);
            SM_GT:   pair_op(c, sts_pkg::TT_GE, sts_pkg::TT_GT, redo);
            SM_AMP, SM_BAR:
                if (c == (mode == SM_AMP ? "&" : "|"))
                begin
                    emit(sts_pkg::RK_TOKEN,
                         mode == SM_AMP ? sts_pkg::TT_ANDAND : sts_pkg::TT_OROR,
                         tok_start, 16'd2, sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                end
                else
                    raise_error(tok_start, sts_pkg::ERR_BAD_CHAR);
            SM_INT:
                if (c == ".")
                    mode = SM_INTDOT;
                else if (!is_digit(c))
                begin
                    emit(sts_pkg::RK_TOKEN, sts_pkg::TT_NUMBER, tok_start, len,
                         sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                    redo = 1'b1;
                end
            SM_INTDOT:
                if (is_digit(c))
                    mode = SM_FRAC;
                else
                begin
                    // The dot after an integer becomes an attribute token of its own.
                    emit(sts_pkg::RK_TOKEN, sts_pkg::TT_NUMBER, tok_start,
                         sat_sub(len, 16'd1), sts_pkg::ERR_NONE);
                    emit(sts_pkg::RK_TOKEN, sts_pkg::TT_DOT, sat_sub(p, 16'd1), 16'd1,
                         sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                    redo = 1'b1;
                end
            SM_FRAC:
                if (!is_digit(c))
                begin
                    emit(sts_pkg::RK_TOKEN, sts_pkg::TT_NUMBER, tok_start, len,
                         sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                    redo = 1'b1;
                end
            SM_NAME:
                if (is_alpha(c) || is_digit(c))
                begin
                    if (len < 8)
                        prefix[len] = c;
                end
                else
                begin
                    emit(sts_pkg::RK_TOKEN, classify_name(len), tok_start, len,
                         sts_pkg::ERR_NONE);
                    mode = SM_IDLE;
                    redo = 1'b1;
                end
            default:
            begin
                mode = SM_IDLE;
                redo = 1'b1;
            end
        endcase
        if (redo && mode == SM_IDLE)
            start_token(c, p);
        if (c != 8'h00 && mode != SM_HALT && pos != POS_TOP)
            pos++;
        if (step_q.size() > 0)
            step_q[$].last_of_run = 1'b1;
        foreach (step_q[i])
            token_q.push_back(step_q[i]);
    endtask

    task automatic check_result();
        sts_pkg::res_t got;
        sts_pkg::res_t want;
        got = '{result_kind, token_type, token_offset, token_length, line_number,
                error_code, last_of_run};
        if (token_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result: kind %0d type %0d off %0d len %0d line %0d err %0d",
                         got.result_kind, got.token_type, got.token_offset,
                         got.token_length, got.line_number, got.error_code);
            return;
        end
        want = token_q.pop_front();
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display({"Mismatch: expected kind %0d type %0d off %0d len %0d line %0d ",
                          "err %0d last %0d, got kind %0d type %0d off %0d len %0d line %0d ",
                          "err %0d last %0d"},
                         want.result_kind, want.token_type, want.token_offset,
                         want.token_length, want.line_number, want.error_code,
                         want.last_of_run, got.result_kind, got.token_type,
                         got.token_offset, got.token_length, got.line_number,
                         got.error_code, got.last_of_run);
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart();
            token_q.delete();
            pending = 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                scan_byte(kind, text_byte);
            if (res_valid && !res_stall)
                check_result();
            pending = token_q.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the script token scanner testbench: stimulus, receiver stalls and verdict.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_GOAL   = 360;
    localparam int SETTLE      = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    logic        kind = 1'b0;
    logic [7:0]  text_byte = 8'd0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [5:0]  token_type;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_run;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          items_sent = 0;
    int          stall_left = 0;
    bit          steady = 1'b0;
    logic [8:0]  text_q [$];

    string keyword_words[10] = '{"var", "array", "function", "return", "class",
                                 "if", "elif", "else", "while", "break"};
    string operator_words[24] = '{"==", "=", ";", "{", "(", ")", "[", "]", "}", ".", ",",
                                  "+", "-", "*", "/", "!=", "!", "&&", "||", "<=", "<",
                                  ">=", ">", "$"};
    string ident_chars =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    script_token_scanner uut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall),
        .kind(kind), .text_byte(text_byte),
        .res_valid(res_valid), .res_stall(res_stall),
        .result_kind(result_kind), .token_type(token_type),
        .token_offset(token_offset), .token_length(token_length),
        .line_number(line_number), .error_code(error_code),
        .last_of_run(last_of_run)
    );

    scanner_checker scan_check (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall),
        .kind(kind), .text_byte(text_byte),
        .res_valid(res_valid), .res_stall(res_stall),
        .result_kind(result_kind), .token_type(token_type),
        .token_offset(token_offset), .token_length(token_length),
        .line_number(line_number), .error_code(error_code),
        .last_of_run(last_of_run),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The run is cut off if it hangs; a correct run stays far below this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls in random bursts, mostly short and now and then long.
    // While steady is set, it starts no new stall and takes every result once a running burst ends.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 30)
        begin
            res_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
        end
        else
            res_stall <= 1'b0;
    end

    // Gap before the next transfer: usually none or a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Presents one item and holds it until the scanner takes it. With no gap the
    // valid stays high from the previous transfer, so it is never lowered and raised
    // within one time step.
    task automatic send(logic k, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        kind      <= k;
        text_byte <= b;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic put(logic [7:0] b);
        text_q.push_back({1'b0, b});
    endtask

    task automatic put_word(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    // An end is either a NUL text byte or an end item with a random byte, which the scanner must ignore.
    task automatic put_end();
        if ($urandom_range(0, 2) == 0)
            put(8'h00);
        else
            text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic flush_text();
        logic [8:0] item;
        while (text_q.size() > 0)
        begin
            item = text_q.pop_front();
            send(item[8], item[7:0]);
        end
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One random piece of well-formed source text. Strings and comments carry random nonzero
    // bytes other than their closing one, high ones included, since only that byte and newlines are looked at.
    task automatic put_fragment();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                put_word(keyword_words[$urandom_range(0, 9)]);
                if ($urandom_range(0, 3) == 0)
                    put(ident_chars[$urandom_range(0, 62)]);
            end
            2:
            begin
                n = $urandom_range(1, 12);
                put(ident_chars[$urandom_range(0, 52)]);
                for (int i = 1; i < n; i++)
                    put(ident_chars[$urandom_range(0, 62)]);
            end
            3:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    put(8'("0") + 8'($urandom_range(0, 9)));
                case ($urandom_range(0, 2))
                    0: ;
                    1:
                    begin
                        put(".");
                        put(8'("0") + 8'($urandom_range(0, 9)));
                        put(8'("0") + 8'($urandom_range(0, 9)));
                    end
                    default:
                    begin
                        put(".");
                        put(ident_chars[$urandom_range(0, 52)]);
                    end
                endcase
            end
            4:
            begin
                put(sts_pkg::CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == sts_pkg::CH_QUOTE);
                    put(b);
                end
                put(sts_pkg::CH_QUOTE);
            end
            5:
            begin
                put_word("//");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == "\n");
                    put(b);
                end
                put("\n");
            end
            6, 7: put_word(operator_words[$urandom_range(0, 23)]);
            default:
                case ($urandom_range(0, 2))
                    0: put(" ");
                    1: put("\t");
                    default: put("\n");
                endcase
        endcase
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: a double operator, a decimal, a dot after an integer,
        // a comment closed by a newline, a string across a line, a trailing
        // operator and name flushed by the end, a NUL as end, an empty text,
        // and an end item with all ones in the byte.
        put_word("a==1.5!x\n//c\n");
        put_word("\"q\nr\"7.y>");
        put(8'h00);
        text_q.push_back({1'b1, 8'hFF});
        put_word("while$<=");
        put_word("foo");
        text_q.push_back({1'b1, 8'h00});
        flush_text();

        // The source holds back until every expected result has arrived.
        wait_drained();

        while (items_sent < ITEM_GOAL - 40)
        begin
            steady = ($urandom_range(0, 5) == 0);
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                put_fragment();
            put_end();
            flush_text();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        steady = 1'b0;

        // The scanner halts for good after an error, so one error case closes
        // the run: a bad byte, a lone & or |, or a string left open.
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            put_fragment();
        case ($urandom_range(0, 3))
            0:
                case ($urandom_range(0, 2))
                    0: put(8'($urandom_range(128, 255)));
                    1: put(8'h0D);
                    default: put("#");
                endcase
            1: begin put("&"); put("x"); end
            2: begin put("|"); put_end(); end
            default: begin put(sts_pkg::CH_QUOTE); put("z"); put_end(); end
        endcase
        // Input after the halt must be absorbed without any result.
        repeat (4)
            put(8'($urandom_range(0, 255)));
        flush_text();

        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
